// ----- rtl/sensor_packet_framer_top_macros.svh -----
// Assertion macros shared by the sensor packet framer modules.
`ifndef SENSOR_PACKET_FRAMER_TOP_MACROS_SVH
`define SENSOR_PACKET_FRAMER_TOP_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define SPF_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition seen at one edge leads to another at the next edge.
`define SPF_CHECK_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/spf_pkg.sv -----
// Package with the types and constants of the sensor packet framer.
`timescale 1ns / 1ps

package spf_pkg;

   localparam int NUM_LINKS_DEF = 2;
   localparam int PACKET_BYTES  = 28;
   localparam int COUNT_W       = 5;

   typedef logic [COUNT_W-1:0] count_type;

   localparam logic [7:0] HEADER_BYTE = 8'hFF;
   localparam logic [7:0] FOOTER_BYTE = 8'hFE;

   // Packet byte positions.
   localparam count_type COUNT_AFTER_FIRST = count_type'(1);
   localparam count_type COUNT_AFTER_HDR   = count_type'(2);
   localparam count_type SPACE_POS         = count_type'(8);
   localparam count_type STATUS_POS        = count_type'(25);
   localparam count_type FOOTER_POS        = count_type'(PACKET_BYTES - 1);

   localparam int SPACE_IDX  = 8;
   localparam int INDEX_IDX  = 9;
   localparam int PLOW_IDX   = 10;
   localparam int PHIGH_IDX  = 17;
   localparam int BATT_IDX   = 24;
   localparam int STATUS_IDX = 25;

   // Bytes 8 to 25 are kept per link in one shifted row.
   localparam int ROW_BYTES = STATUS_IDX - SPACE_IDX + 1;
   localparam int ROW_W     = 8 * ROW_BYTES;
   localparam int FIELD56_W = 56;

   typedef logic [ROW_W-1:0] row_type;

   typedef enum logic [1:0] {
      PH_WAIT0   = 2'd0,
      PH_WAIT1   = 2'd1,
      PH_COLLECT = 2'd2
   } phase_type;

   typedef struct packed {
      logic        channel;
      logic [7:0]  rx_byte;
      logic [31:0] now_tick;
   } item_type;

   typedef struct packed {
      logic                 channel_out;
      logic [31:0]          timestamp;
      logic [7:0]           sensor_space;
      logic [7:0]           rolling_index;
      logic [FIELD56_W-1:0] pressure_low;
      logic [FIELD56_W-1:0] pressure_high;
      logic [7:0]           battery_level;
      logic [7:0]           status_flags;
   } result_type;

endpackage

// ----- rtl/sensor_packet_framer_top.sv -----
// Top level of the sensor packet framer: input register, framer and result register.
`timescale 1ns / 1ps

// The block accepts one received byte per clock cycle on the req_ channel and keeps an
// independent framer for each sensor link. A packet is two 0xFF header bytes followed by
// data to 28 bytes in all. When byte 27 is the 0xFE footer, one result transfer is
// offered on the rsp_ channel. It carries the link, the tick of the completing byte and the
// decoded fields. The completing byte waits in the input register while it is parsed, and its
// result then moves into the result register, from which the transfer is offered.
// Packets with a bad footer are dropped without any output. The sustained rate is one byte
// per cycle: the byte sits in an input register while its framer state is updated, and its
// result, if any, moves into a result register. The input is stalled only when a completing
// byte finds the result register still full and the output stalled; bytes that finish no
// packet keep flowing. Bytes on a channel number at or above NUM_LINKS are accepted and
// ignored.

module sensor_packet_framer_top
   import spf_pkg::*;
#(
   parameter int NUM_LINKS = NUM_LINKS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_channel,
   input  logic [7:0]           req_rx_byte,
   input  logic [31:0]          req_now_tick,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_channel_out,
   output logic [31:0]          rsp_timestamp,
   output logic [7:0]           rsp_sensor_space,
   output logic [7:0]           rsp_rolling_index,
   output logic [FIELD56_W-1:0] rsp_pressure_low,
   output logic [FIELD56_W-1:0] rsp_pressure_high,
   output logic [7:0]           rsp_battery_level,
   output logic [7:0]           rsp_status_flags
);

   `include "sensor_packet_framer_top_macros.svh"

   item_type   req_item;
   item_type   s1_item;
   logic       s1_valid;
   logic       emit;
   result_type result;
   logic       out_free;
   logic       s1_advance;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;

   assign req_item.channel  = req_channel;
   assign req_item.rx_byte  = req_rx_byte;
   assign req_item.now_tick = req_now_tick;

   // The result register can take a new transfer when it is empty or being emptied.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // A byte leaves the input register unless it completes a packet and the result
   // register cannot take it.
   assign s1_advance = s1_valid && (!emit || out_free);
   assign req_stall  = s1_valid && !s1_advance;

   spf_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (!req_stall),
      .in_valid   (req_valid),
      .in_item    (req_item),
      .item_valid (s1_valid),
      .item       (s1_item)
   );

   // The framer state advances only when the byte leaves the input register, so each
   // byte is applied exactly once even while it waits for the output.
   spf_framer #(
      .NUM_LINKS (NUM_LINKS)
   ) u_framer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid),
      .fire       (s1_advance),
      .item       (s1_item),
      .emit       (emit),
      .result     (result)
   );

   always_comb begin
      if (s1_advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_out   = rsp_data_ff.channel_out;
   assign rsp_timestamp     = rsp_data_ff.timestamp;
   assign rsp_sensor_space  = rsp_data_ff.sensor_space;
   assign rsp_rolling_index = rsp_data_ff.rolling_index;
   assign rsp_pressure_low  = rsp_data_ff.pressure_low;
   assign rsp_pressure_high = rsp_data_ff.pressure_high;
   assign rsp_battery_level = rsp_data_ff.battery_level;
   assign rsp_status_flags  = rsp_data_ff.status_flags;

   `SPF_CHECK(a_no_overwrite,
      (rsp_valid_ff && rsp_stall && s1_valid && emit) |-> req_stall,
      "completed packet would overwrite a result still waiting for transfer")
   `SPF_CHECK_NEXT(a_no_phantom,
      (out_free && !(s1_advance && emit)), !rsp_valid_ff,
      "result register holds a transfer that no completed packet produced")

endmodule

// ----- rtl/spf_in_reg.sv -----
// Input register stage of the sensor packet framer.
`timescale 1ns / 1ps

module spf_in_reg
   import spf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign valid_in = load ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- rtl/spf_framer.sv -----
// Per-link framer state and the combinational packet parser.
`timescale 1ns / 1ps

module spf_framer
   import spf_pkg::*;
#(
   parameter int NUM_LINKS = NUM_LINKS_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  logic       fire,
   input  item_type   item,
   output logic       emit,
   output result_type result
);

   `include "sensor_packet_framer_top_macros.svh"

   localparam int LINK_W = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

   phase_type phase_ff [NUM_LINKS];
   count_type count_ff [NUM_LINKS];
   row_type   row_ff   [NUM_LINKS];

   logic              link_ok;
   logic [LINK_W-1:0] rd_idx;
   phase_type         phase;
   count_type         cnt;
   row_type           row;
   phase_type         phase_in;
   count_type         count_in;
   row_type           row_in;

   // Channels beyond the configured links are ignored entirely.
   assign link_ok = 32'(item.channel) < NUM_LINKS;
   assign rd_idx  = link_ok ? LINK_W'(item.channel) : '0;
   assign phase   = phase_ff[rd_idx];
   assign cnt     = count_ff[rd_idx];
   assign row     = row_ff[rd_idx];

   // Next state of the addressed link.
   always_comb begin
      phase_in = phase;
      count_in = cnt;
      row_in   = row;
      case (phase)
         PH_WAIT1: begin
            if (item.rx_byte == HEADER_BYTE) begin
               count_in = COUNT_AFTER_HDR;
               phase_in = PH_COLLECT;
            end else begin
               count_in = '0;
               phase_in = PH_WAIT0;
            end
         end
         PH_COLLECT: begin
            if (cnt inside {[SPACE_POS:STATUS_POS]}) begin
               row_in = {item.rx_byte, row[ROW_W-1:8]};
            end
            if (cnt >= FOOTER_POS) begin
               count_in = '0;
               phase_in = PH_WAIT0;
            end else begin
               count_in = count_type'(cnt + 1'b1);
            end
         end
         default: begin
            if (item.rx_byte == HEADER_BYTE) begin
               count_in = COUNT_AFTER_FIRST;
               phase_in = PH_WAIT1;
            end
         end
      endcase
   end

   // Result of the item: the last byte of a packet is the footer itself.
   always_comb begin
      emit = item_valid && link_ok && (phase == PH_COLLECT) && (cnt >= FOOTER_POS)
             && (item.rx_byte == FOOTER_BYTE);
      result.channel_out   = item.channel;
      result.timestamp     = item.now_tick;
      result.sensor_space  = row[8*(SPACE_IDX-SPACE_IDX) +: 8];
      result.rolling_index = row[8*(INDEX_IDX-SPACE_IDX) +: 8];
      result.pressure_low  = row[8*(PLOW_IDX-SPACE_IDX) +: FIELD56_W];
      result.pressure_high = row[8*(PHIGH_IDX-SPACE_IDX) +: FIELD56_W];
      result.battery_level = row[8*(BATT_IDX-SPACE_IDX) +: 8];
      result.status_flags  = row[8*(STATUS_IDX-SPACE_IDX) +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LINKS; i++) begin
            phase_ff[i] <= PH_WAIT0;
            count_ff[i] <= '0;
         end
      end else if (fire && link_ok) begin
         phase_ff[rd_idx] <= phase_in;
         count_ff[rd_idx] <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && link_ok) begin
         row_ff[rd_idx] <= row_in;
      end
   end

   `SPF_CHECK(a_collect_count,
      (item_valid && phase == PH_COLLECT) |-> (cnt >= COUNT_AFTER_HDR && cnt <= FOOTER_POS),
      "collecting link holds a byte count outside the packet")
   `SPF_CHECK(a_wait1_count,
      (item_valid && phase == PH_WAIT1) |-> (cnt == COUNT_AFTER_FIRST),
      "link waiting for the second header does not hold exactly one byte")

endmodule
